@@ sv/bdeq_pkg.sv @@
package bdeq_pkg;

   localparam int DEPTH = 64;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int POS_W = 6;
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_READ       = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef struct packed {
      logic load;     // capture the request fields
      logic execute;  // perform the operation on the store and pointers
   } dp_cmd_type;

   // Ring index of an offset from a base; the offset never exceeds DEPTH.
   function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                 input logic [CNT_W-1:0] offset);
      logic [CNT_W:0] sum;
      sum = {{(CNT_W + 1 - PTR_W){1'b0}}, base} + {1'b0, offset};
      if (sum >= (CNT_W + 1)'(DEPTH)) begin
         sum = sum - (CNT_W + 1)'(DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

endpackage

@@ sv/bdeq_ctrl.sv @@
module bdeq_ctrl
   import bdeq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   output logic       rsp_valid,
   output dp_cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign busy      = (state_ff == S_EXEC);
   assign accept    = start && !busy;
   assign rsp_valid = (state_ff == S_RESP);

   assign cmd.load    = accept;
   assign cmd.execute = (state_ff == S_EXEC);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            // A new item may be taken while the result is on the ports.
            state_in = accept ? S_EXEC : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ sv/bdeq_datapath.sv @@
module bdeq_datapath
   import bdeq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  dp_cmd_type       cmd,
   input  logic [2:0]       req_opcode,
   input  logic [7:0]       req_push_byte,
   input  logic [POS_W-1:0] req_position,
   output logic [7:0]       rsp_out_byte,
   output logic [1:0]       rsp_status,
   output logic [6:0]       rsp_fill_count
);

   logic [7:0] mem [DEPTH];

   logic [2:0]       op_ff;
   logic [7:0]       byte_ff;
   logic [POS_W-1:0] pos_ff;

   logic [PTR_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] count_ff, count_in;
   status_type       status_ff, status_in;
   logic             show_ff, show_in;
   logic [7:0]       rd_data_ff;

   logic [PTR_W-1:0] addr;
   logic             mem_wr, mem_rd;
   logic             full, empty;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      status_in = ST_OK;
      show_in   = 1'b0;
      addr      = front_ff;
      mem_wr    = 1'b0;
      mem_rd    = 1'b0;
      case (op_ff)
         OP_PUSH_FRONT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               addr     = ring_add(front_ff, CNT_W'(DEPTH - 1));
               front_in = addr;
               mem_wr   = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         OP_PUSH_BACK: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               addr     = ring_add(front_ff, count_ff);
               mem_wr   = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         OP_POP_FRONT: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               addr     = front_ff;
               mem_rd   = 1'b1;
               show_in  = 1'b1;
               front_in = ring_add(front_ff, CNT_W'(1));
               count_in = count_ff - 1'b1;
            end
         end
         OP_POP_BACK: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               addr     = ring_add(front_ff, count_ff - 1'b1);
               mem_rd   = 1'b1;
               show_in  = 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
         OP_READ: begin
            if (CMP_W'(pos_ff) >= CMP_W'(count_ff)) begin
               status_in = ST_RANGE;
            end else begin
               // The position is below the count here, so it fits the count width.
               addr    = ring_add(front_ff, CNT_W'(pos_ff));
               mem_rd  = 1'b1;
               show_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_opcode;
         byte_ff <= req_push_byte;
         pos_ff  <= req_position;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute && mem_wr) begin
         mem[addr] <= byte_ff;
      end
      if (cmd.execute && mem_rd) begin
         rd_data_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff  <= '0;
         count_ff  <= '0;
         status_ff <= ST_OK;
         show_ff   <= 1'b0;
      end else if (cmd.execute) begin
         front_ff  <= front_in;
         count_ff  <= count_in;
         status_ff <= status_in;
         show_ff   <= show_in;
      end
   end

   assign rsp_out_byte   = show_ff ? rd_data_ff : 8'd0;
   assign rsp_status     = status_ff;
   assign rsp_fill_count = 7'(count_ff);

endmodule

@@ sv/byte_double_ended_queue.sv @@
// Bounded double-ended queue of bytes held in a ring buffer.
// An item is taken at a rising edge with start high and busy low. It carries an
// opcode (push front, push back, pop front, pop back, read at position), the byte
// to push and the position to read.
// Each item gives exactly one result: rsp_valid is high for one cycle, the cycle
// after busy. It carries the byte popped or read (zero otherwise), a status
// (ok, empty, full, out of range) and the count after the operation.
// The result is accepted at the edge that ends that cycle; the receiver cannot
// hold it off, so it must sample every strobe.
// busy is high for the one cycle in which the store and pointers are updated.
// A new item may be given in the cycle its predecessor's result is shown, but
// not while busy. The single store port is used once per item, with registered
// read data.
// A failed operation leaves the contents and pointers unchanged. Unused opcodes
// report ok with the current count.
// Reset clears the front pointer and the count; the store keeps whatever it held
// and needs no clearing pass, since only written entries are ever read.
module byte_double_ended_queue
   import bdeq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [2:0]       req_opcode,
   input  logic [7:0]       req_push_byte,
   input  logic [POS_W-1:0] req_position,
   output logic             rsp_valid,
   output logic [7:0]       rsp_out_byte,
   output logic [1:0]       rsp_status,
   output logic [6:0]       rsp_fill_count
);

   dp_cmd_type cmd;

   bdeq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   bdeq_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_opcode     (req_opcode),
      .req_push_byte  (req_push_byte),
      .req_position   (req_position),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_status     (rsp_status),
      .rsp_fill_count (rsp_fill_count)
   );

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import bdeq_pkg::*;

   localparam int QUIET_LIMIT = 5000;
   localparam int RANDOM_ITEMS = 1900;

   localparam int BURST_FILL = 0;
   localparam int BURST_DRAIN = 1;
   localparam int BURST_MIXED = 2;

   typedef struct packed {
      logic             wait_drain;
      logic [2:0]       opcode;
      logic [7:0]       push_byte;
      logic [POS_W-1:0] position;
   } deq_cmd_type;

   typedef struct packed {
      logic [7:0] out_byte;
      status_type status;
      logic [6:0] fill_count;
   } deq_rsp_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic [2:0]       req_opcode = '0;
   logic [7:0]       req_push_byte = '0;
   logic [POS_W-1:0] req_position = '0;
   logic             rsp_valid;
   logic [7:0]       rsp_out_byte;
   logic [1:0]       rsp_status;
   logic [6:0]       rsp_fill_count;

   deq_cmd_type pending_cmds[$];
   deq_rsp_type expected_rsps[$];
   deq_cmd_type live_cmd;

   // Shadow copy of the ring buffer.
   logic [7:0]       ring_bytes[DEPTH];
   logic [PTR_W-1:0] ring_head;
   logic [CNT_W-1:0] ring_fill;

   int issued_count = 0;
   int total_cmds = 0;
   int error_count = 0;
   int quiet_cycles = 0;

   byte_double_ended_queue u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_push_byte  (req_push_byte),
      .req_position   (req_position),
      .rsp_valid      (rsp_valid),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_status     (rsp_status),
      .rsp_fill_count (rsp_fill_count)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // Applies one item to the shadow queue and returns the result it must give.
   function automatic deq_rsp_type deque_step(input deq_cmd_type c);
      deq_rsp_type r;
      logic [PTR_W-1:0] slot;
      r.out_byte = '0;
      r.status = ST_OK;
      case (c.opcode)
         OP_PUSH_FRONT: begin
            if (ring_fill == DEPTH) begin
               r.status = ST_FULL;
            end else begin
               ring_head = ring_head - 1'b1;
               ring_bytes[ring_head] = c.push_byte;
               ring_fill = ring_fill + 1'b1;
            end
         end
         OP_PUSH_BACK: begin
            if (ring_fill == DEPTH) begin
               r.status = ST_FULL;
            end else begin
               slot = ring_head + ring_fill[PTR_W-1:0];
               ring_bytes[slot] = c.push_byte;
               ring_fill = ring_fill + 1'b1;
            end
         end
         OP_POP_FRONT: begin
            if (ring_fill == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.out_byte = ring_bytes[ring_head];
               ring_head = ring_head + 1'b1;
               ring_fill = ring_fill - 1'b1;
            end
         end
         OP_POP_BACK: begin
            if (ring_fill == 0) begin
               r.status = ST_EMPTY;
            end else begin
               slot = ring_head + PTR_W'(ring_fill - 1'b1);
               r.out_byte = ring_bytes[slot];
               ring_fill = ring_fill - 1'b1;
            end
         end
         OP_READ: begin
            if (c.position >= ring_fill) begin
               r.status = ST_RANGE;
            end else begin
               slot = ring_head + c.position;
               r.out_byte = ring_bytes[slot];
            end
         end
         default: begin
         end
      endcase
      r.fill_count = ring_fill;
      return r;
   endfunction

   task automatic add_cmd(input logic [2:0] op, input logic [7:0] data,
                          input logic [POS_W-1:0] pos, input logic wait_drain);
      deq_cmd_type c;
      c.wait_drain = wait_drain;
      c.opcode = op;
      c.push_byte = data;
      c.position = pos;
      pending_cmds.push_back(c);
   endtask

   task automatic add_burst(input int kind, input logic wait_drain);
      int n;
      int pick;
      logic [2:0] op;
      logic [POS_W-1:0] pos;
      n = (kind == BURST_MIXED) ? $urandom_range(40, 10) : $urandom_range(80, 64);
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         pos = ($urandom_range(1) == 1) ? POS_W'($urandom_range(7)) : POS_W'($urandom);
         if (kind == BURST_FILL) begin
            op = (pick < 80) ? ($urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT) : OP_READ;
            if (op == OP_READ) begin
               pos = POS_W'($urandom);
            end
         end else if (kind == BURST_DRAIN) begin
            op = (pick < 80) ? ($urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT) : OP_READ;
         end else if (pick < 40) begin
            op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
         end else if (pick < 70) begin
            op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
         end else if (pick < 95) begin
            op = OP_READ;
         end else begin
            op = 3'($urandom_range(7, OP_READ + 1));
         end
         add_cmd(op, 8'($urandom), pos, (i == 0) ? wait_drain : 1'b0);
      end
   endtask

   // Driver: keeps start high until the item is taken, then offers the next one or drops start.
   always @(posedge clock) begin
      deq_cmd_type nxt;
      logic offering;
      int idle_pct;
      if (reset) begin
         start <= 1'b0;
         ring_head = '0;
         ring_fill = '0;
      end else begin
         offering = start;
         if (start && !busy) begin
            expected_rsps.push_back(deque_step(live_cmd));
            issued_count++;
            offering = 1'b0;
         end
         if (!offering) begin
            if (issued_count < total_cmds / 3) begin
               idle_pct = 10;
            end else if (issued_count < 2 * total_cmds / 3) begin
               idle_pct = 68;
            end else begin
               idle_pct = 0;
            end
            if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct
                && !(pending_cmds[0].wait_drain && expected_rsps.size() != 0)) begin
               nxt = pending_cmds.pop_front();
               live_cmd = nxt;
               req_opcode <= nxt.opcode;
               req_push_byte <= nxt.push_byte;
               req_position <= nxt.position;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobe must match the oldest waiting expectation.
   always @(posedge clock) begin
      deq_rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected result: out_byte %0d status %0d fill_count %0d",
                   rsp_out_byte, rsp_status, rsp_fill_count);
            error_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_out_byte !== want.out_byte) begin
               $error("out_byte: expected %0d, got %0d", want.out_byte, rsp_out_byte);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_fill_count !== want.fill_count) begin
               $error("fill_count: expected %0d, got %0d", want.fill_count,
                      rsp_fill_count);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      // Pops and reads on an empty queue, then the unused opcodes, then pushes at both ends, reads and pops past empty.
      add_cmd(OP_POP_FRONT, 8'h00, '0, 1'b0);
      add_cmd(OP_POP_BACK, 8'hFF, '1, 1'b0);
      add_cmd(OP_READ, 8'h00, '0, 1'b0);
      add_cmd(OP_READ, 8'hFF, '1, 1'b0);
      for (int k = OP_READ + 1; k < 8; k++) begin
         add_cmd(3'(k), 8'($urandom), POS_W'($urandom), 1'b0);
      end
      add_cmd(OP_PUSH_FRONT, 8'hFF, '0, 1'b0);
      add_cmd(OP_PUSH_BACK, 8'h00, '1, 1'b0);
      add_cmd(OP_PUSH_FRONT, 8'h80, '0, 1'b1);
      add_cmd(OP_PUSH_BACK, 8'h01, '0, 1'b0);
      for (int k = 0; k < 5; k++) begin
         add_cmd(OP_READ, 8'h00, POS_W'(k), 1'b0);
      end
      add_cmd(OP_READ, 8'h00, '1, 1'b0);
      add_cmd(OP_POP_FRONT, 8'h00, '0, 1'b0);
      add_cmd(OP_POP_BACK, 8'h00, '0, 1'b0);
      add_cmd(OP_POP_FRONT, 8'h00, '0, 1'b0);
      add_cmd(OP_POP_BACK, 8'h00, '0, 1'b0);
      add_cmd(OP_POP_BACK, 8'h00, '0, 1'b0);

      // A push-heavy fill burst and a pop-heavy drain burst first, then random bursts.
      add_burst(BURST_FILL, 1'b1);
      add_burst(BURST_DRAIN, 1'b0);
      while (pending_cmds.size() < RANDOM_ITEMS) begin
         add_burst($urandom_range(BURST_MIXED), ($urandom_range(7) == 0));
      end
      total_cmds = pending_cmds.size();

      while ((pending_cmds.size() != 0 || start || expected_rsps.size() != 0)
             && quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("byte_double_ended_queue: mismatch");
      end else begin
         repeat (8) @(posedge clock);
         if (expected_rsps.size() != 0) begin
            $error("%0d results never arrived", expected_rsps.size());
            error_count++;
         end
         if (error_count == 0) begin
            $display("byte_double_ended_queue: match");
         end else begin
            $display("byte_double_ended_queue: mismatch");
         end
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/bdeq_pkg.sv
sv/bdeq_ctrl.sv
sv/bdeq_datapath.sv
sv/byte_double_ended_queue.sv
verif/tb.sv
